>>> rtl/falu_pkg.sv
package falu_pkg;

  localparam int FRAC_BITS_DEF = 8;
  localparam int WORD_BITS_DEF = 32;

  typedef enum logic [3:0] {
    CMD_ADD      = 4'd0,
    CMD_SUB      = 4'd1,
    CMD_MUL      = 4'd2,
    CMD_DIV      = 4'd3,
    CMD_CMP      = 4'd4,
    CMD_MAX      = 4'd5,
    CMD_MIN      = 4'd6,
    CMD_INC      = 4'd7,
    CMD_DEC      = 4'd8,
    CMD_TO_INT   = 4'd9,
    CMD_FROM_INT = 4'd10
  } cmd_t;

  // Flag bit positions inside out_tuser.
  localparam int FLG_LESS = 0;
  localparam int FLG_EQUAL = 1;
  localparam int FLG_GREATER = 2;
  localparam int FLG_OVF = 3;
  localparam int FLG_DZ = 4;
  localparam int FLG_BITS = 5;

endpackage

>>> rtl/falu_div_stage.sv
module falu_div_stage #(
  parameter int W  = 32,
  parameter int NB = 40
) (
  input  logic [W:0]    rem_i,
  input  logic [NB-1:0] num_i,
  input  logic [NB-1:0] quo_i,
  input  logic [W-1:0]  den_i,
  output logic [W:0]    rem_o,
  output logic [NB-1:0] num_o,
  output logic [NB-1:0] quo_o
);

  logic [W:0] shifted;
  logic       ge;

  // One restoring step: bring down the next numerator bit, subtract if it fits.
  always_comb begin
    shifted = {rem_i[W-1:0], num_i[NB-1]};
    ge      = shifted >= {1'b0, den_i};
    rem_o   = ge ? (shifted - {1'b0, den_i}) : shifted;
    num_o   = {num_i[NB-2:0], 1'b0};
    quo_o   = {quo_i[NB-2:0], ge};
  end

endmodule

>>> rtl/fixed_point_alu.sv
// Signed fixed-point ALU, one word in and one word out per operation.
// Input channel: in_tuser carries the opcode, in_tdata the two raw operands.
// Output channel: out_tdata carries the raw result, out_tuser the flags.
// Every operation goes through the same pipeline of WORD_BITS+FRAC_BITS+3
// register stages: one input stage that computes the simple operations and
// operand magnitudes, one stage per quotient bit of the restoring divider,
// a rounding stage and a saturation stage that also serves as the output
// register. The multiplier runs beside the divider as two stages of
// half-width partial products and their sum.
// One word per cycle while out_tready is high; results leave in arrival order.
// Each stage moves on when the stage after it is empty or moving, so a stall
// at the output fills the bubbles first and in_tready falls only once the
// whole pipeline holds words. Nothing is lost or repeated under a stall.
// A synchronous reset (rst_n low) empties the pipeline; no other state exists.
module fixed_point_alu
  import falu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   in_tvalid,
  output logic                                   in_tready,
  // operand_a, operand_b, zero fill
  input  logic [((2*WORD_BITS+7)/8)*8-1:0]      in_tdata,
  // cmd
  input  logic [3:0]                             in_tuser,
  output logic                                   out_tvalid,
  input  logic                                   out_tready,
  // result, zero fill
  output logic [((WORD_BITS+7)/8)*8-1:0]        out_tdata,
  // less, equal, greater, overflow, div_zero
  output logic [FLG_BITS-1:0]                    out_tuser
);

  localparam int W   = WORD_BITS;
  localparam int F   = FRAC_BITS;
  localparam int NB  = W + F;
  localparam int PW  = 2 * W;
  localparam int MW  = ((NB > PW - F) ? NB : (PW - F)) + 1;
  localparam int H   = (W + 1) / 2;
  localparam int N   = NB + 3;
  localparam int E1  = NB + 1;
  localparam int E2  = NB + 2;
  localparam int RB  = (F > 0) ? F - 1 : 0;
  localparam int ODW = ((W + 7) / 8) * 8;

  localparam logic [W-1:0] MAXV = {1'b0, {(W-1){1'b1}}};
  localparam logic [W-1:0] MINV = {1'b1, {(W-1){1'b0}}};

  // Pipeline control.
  logic         v_r   [N];
  logic [N:0]   en;
  cmd_t         cmd_r [N];
  logic [W-1:0] simp_r [N];
  logic [FLG_BITS-1:0] flg_r [N];
  logic         neg_r [N];

  // Divider chain.
  logic [W:0]    rem_r [NB+1];
  logic [NB-1:0] num_r [NB+1];
  logic [NB-1:0] quo_r [NB+1];
  logic [W-1:0]  den_r [NB+1];
  logic [W-1:0]  ma_r;

  // Multiplier.
  logic [PW-1:0] pp_r [4];
  logic [PW-1:0] prod_r [N];

  logic [MW-1:0] sum_r;

  always_comb begin
    en[N] = out_tready;
    for (int k = N - 1; k >= 0; k--) begin
      en[k] = !v_r[k] || en[k+1];
    end
  end
  assign in_tready = en[0];

  // Input stage: simple operations and magnitudes.
  logic signed [W-1:0]   op_a, op_b, op_c;
  logic signed [W:0]     asum;
  logic signed [NB-1:0]  fw;
  logic [W-1:0]          mag_a, mag_b, simp_nxt;
  logic [FLG_BITS-1:0]   flg_nxt;
  cmd_t                  cmd_in;

  always_comb begin
    cmd_in   = cmd_t'(in_tuser);
    op_a     = $signed(in_tdata[W-1:0]);
    op_b     = $signed(in_tdata[PW-1:W]);
    op_c     = (cmd_in == CMD_INC || cmd_in == CMD_DEC) ? W'(1) : op_b;
    if (cmd_in == CMD_SUB || cmd_in == CMD_DEC) begin
      asum = (W+1)'(op_a) - (W+1)'(op_c);
    end else begin
      asum = (W+1)'(op_a) + (W+1)'(op_c);
    end
    fw       = NB'(op_a) <<< F;
    mag_a    = op_a[W-1] ? (W'(0) - op_a) : op_a;
    mag_b    = op_b[W-1] ? (W'(0) - op_b) : op_b;
    simp_nxt = '0;
    flg_nxt  = '0;
    case (cmd_in)
      CMD_ADD, CMD_SUB, CMD_INC, CMD_DEC: begin
        if (asum[W] != asum[W-1]) begin
          flg_nxt[FLG_OVF] = 1'b1;
          simp_nxt = asum[W] ? MINV : MAXV;
        end else begin
          simp_nxt = asum[W-1:0];
        end
      end
      CMD_DIV: begin
        if (op_b == '0) begin
          flg_nxt[FLG_DZ] = 1'b1;
          simp_nxt = op_a[W-1] ? MINV : MAXV;
        end
      end
      CMD_CMP: begin
        flg_nxt[FLG_LESS]    = op_a < op_b;
        flg_nxt[FLG_EQUAL]   = op_a == op_b;
        flg_nxt[FLG_GREATER] = op_a > op_b;
      end
      CMD_MAX:    simp_nxt = (op_a < op_b) ? op_b : op_a;
      CMD_MIN:    simp_nxt = (op_a > op_b) ? op_b : op_a;
      CMD_TO_INT: simp_nxt = op_a >>> F;
      CMD_FROM_INT: begin
        if (NB'($signed(fw[W-1:0])) != fw) begin
          flg_nxt[FLG_OVF] = 1'b1;
          simp_nxt = op_a[W-1] ? MINV : MAXV;
        end else begin
          simp_nxt = fw[W-1:0];
        end
      end
      default: simp_nxt = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r[0] <= 1'b0;
    end else if (en[0]) begin
      v_r[0] <= in_tvalid;
    end
    if (en[0]) begin
      cmd_r[0]  <= cmd_in;
      simp_r[0] <= simp_nxt;
      flg_r[0]  <= flg_nxt;
      neg_r[0]  <= op_a[W-1] ^ op_b[W-1];
      rem_r[0]  <= '0;
      num_r[0]  <= NB'(mag_a) << F;
      quo_r[0]  <= '0;
      den_r[0]  <= mag_b;
      ma_r      <= mag_a;
      prod_r[0] <= '0;
    end
  end

  // Common carry of control and side results through every later stage.
  for (genvar k = 1; k < N; k++) begin : g_carry
    always_ff @(posedge clk) begin
      if (!rst_n) begin
        v_r[k] <= 1'b0;
      end else if (en[k]) begin
        v_r[k] <= v_r[k-1];
      end
      if (en[k]) begin
        cmd_r[k] <= cmd_r[k-1];
        neg_r[k] <= neg_r[k-1];
        if (k != E2) begin
          simp_r[k] <= simp_r[k-1];
          flg_r[k]  <= flg_r[k-1];
        end
        if (k > 2) begin
          prod_r[k] <= prod_r[k-1];
        end
      end
    end
  end

  // Divider stages.
  for (genvar k = 1; k <= NB; k++) begin : g_div
    logic [W:0]    rem_nxt;
    logic [NB-1:0] num_nxt, quo_nxt;

    falu_div_stage #(.W(W), .NB(NB)) u_step (
      .rem_i (rem_r[k-1]),
      .num_i (num_r[k-1]),
      .quo_i (quo_r[k-1]),
      .den_i (den_r[k-1]),
      .rem_o (rem_nxt),
      .num_o (num_nxt),
      .quo_o (quo_nxt)
    );

    always_ff @(posedge clk) begin
      if (en[k]) begin
        rem_r[k] <= rem_nxt;
        num_r[k] <= num_nxt;
        quo_r[k] <= quo_nxt;
        den_r[k] <= den_r[k-1];
      end
    end
  end

  // Multiplier: half-width partial products, then their sum.
  always_ff @(posedge clk) begin
    if (en[1]) begin
      pp_r[0] <= PW'(ma_r[H-1:0] * den_r[0][H-1:0]);
      pp_r[1] <= PW'(ma_r[H-1:0] * den_r[0][W-1:H]);
      pp_r[2] <= PW'(ma_r[W-1:H] * den_r[0][H-1:0]);
      pp_r[3] <= PW'(ma_r[W-1:H] * den_r[0][W-1:H]);
      prod_r[1] <= '0;
    end
    if (en[2]) begin
      prod_r[2] <= pp_r[0] + ((pp_r[1] + pp_r[2]) << H) + (pp_r[3] << (2 * H));
    end
  end

  // Rounding: both multiply and divide round half away from zero on magnitudes.
  logic [MW-1:0] base;
  logic          rnd;
  always_comb begin
    if (cmd_r[E1-1] == CMD_MUL) begin
      base = MW'(prod_r[E1-1] >> F);
      rnd  = (F > 0) ? prod_r[E1-1][RB] : 1'b0;
    end else begin
      base = MW'(quo_r[NB]);
      rnd  = {rem_r[NB], 1'b0} >= {2'b00, den_r[NB]};
    end
  end

  always_ff @(posedge clk) begin
    if (en[E1]) begin
      sum_r <= base + MW'(rnd);
    end
  end

  // Saturation and final selection.
  logic [W-1:0]        res_nxt;
  logic [FLG_BITS-1:0] fo_nxt;
  logic [MW-1:0]       limit;
  always_comb begin
    res_nxt = simp_r[E1];
    fo_nxt  = flg_r[E1];
    limit   = neg_r[E1] ? MW'(MINV) : MW'(MAXV);
    if (cmd_r[E1] == CMD_MUL || (cmd_r[E1] == CMD_DIV && !flg_r[E1][FLG_DZ])) begin
      if (sum_r > limit) begin
        fo_nxt[FLG_OVF] = 1'b1;
        res_nxt = neg_r[E1] ? MINV : MAXV;
      end else begin
        res_nxt = neg_r[E1] ? (W'(0) - sum_r[W-1:0]) : sum_r[W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en[E2]) begin
      simp_r[E2] <= res_nxt;
      flg_r[E2]  <= fo_nxt;
    end
  end

  assign out_tvalid = v_r[E2];
  assign out_tdata  = ODW'(simp_r[E2]);
  assign out_tuser  = flg_r[E2];

  a_dz_no_ovf: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser[FLG_DZ] |-> !out_tuser[FLG_OVF])
    else $error("divide by zero reported together with overflow");

  a_cmp_onehot: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> $onehot0(out_tuser[FLG_GREATER:FLG_LESS]))
    else $error("more than one compare flag set");

  a_adv: assert property (@(posedge clk) disable iff (!rst_n)
    v_r[0] && en[1] |=> v_r[1])
    else $error("word lost between input stage and pipeline");

endmodule

>>> tb/sv/falu_checker.sv
module falu_checker
  import falu_pkg::*;
#(
  parameter int FRAC_BITS = FRAC_BITS_DEF,
  parameter int WORD_BITS = WORD_BITS_DEF
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_tvalid,
  input  logic                             in_tready,
  input  logic [((2*WORD_BITS+7)/8)*8-1:0] in_tdata,
  input  logic [3:0]                       in_tuser,
  input  logic                             out_tvalid,
  input  logic                             out_tready,
  input  logic [((WORD_BITS+7)/8)*8-1:0]   out_tdata,
  input  logic [FLG_BITS-1:0]              out_tuser,
  output int                               errors,
  output int                               pending,
  output int                               results_seen
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [WORD_BITS-1:0] value;
    logic [FLG_BITS-1:0]  flags;
  } alu_result_t;

  localparam logic signed [WORD_BITS+1:0] MAXV = {3'b000, {(WORD_BITS-1){1'b1}}};
  localparam logic signed [WORD_BITS+1:0] MINV = {3'b111, {(WORD_BITS-1){1'b0}}};

  alu_result_t expected_q[$];

  // Clamp a wide exact value into the word range.
  function automatic void clamp(input logic signed [2*WORD_BITS+FRAC_BITS+3:0] v,
                                output logic [WORD_BITS-1:0] r, output logic ovf);
    ovf = 1'b0;
    if (v > MAXV) begin
      r = MAXV[WORD_BITS-1:0];
      ovf = 1'b1;
    end else if (v < MINV) begin
      r = MINV[WORD_BITS-1:0];
      ovf = 1'b1;
    end else begin
      r = v[WORD_BITS-1:0];
    end
  endfunction

  function automatic alu_result_t predict_alu(input logic [3:0] op,
                                              input logic signed [WORD_BITS-1:0] a,
                                              input logic signed [WORD_BITS-1:0] b);
    alu_result_t res;
    logic signed [2*WORD_BITS+FRAC_BITS+3:0] wide;
    logic [2*WORD_BITS+FRAC_BITS+3:0] ma, mb, mag, rem;
    logic neg, ovf;
    res = '0;
    ovf = 1'b0;
    ma = (a < 0) ? -a : a;
    mb = (b < 0) ? -b : b;
    neg = (a < 0) != (b < 0);
    case (op)
      CMD_ADD: begin
        wide = a + b;
        clamp(wide, res.value, ovf);
      end
      CMD_SUB: begin
        wide = a - b;
        clamp(wide, res.value, ovf);
      end
      CMD_INC: begin
        wide = a + 1;
        clamp(wide, res.value, ovf);
      end
      CMD_DEC: begin
        wide = a - 1;
        clamp(wide, res.value, ovf);
      end
      CMD_FROM_INT: begin
        wide = a;
        wide = wide <<< FRAC_BITS;
        clamp(wide, res.value, ovf);
      end
      CMD_TO_INT: res.value = a >>> FRAC_BITS;
      CMD_MUL: begin
        mag = ma * mb;
        if (FRAC_BITS > 0) mag = (mag + (1 << (FRAC_BITS - 1))) >> FRAC_BITS;
        wide = neg ? -$signed(mag) : $signed(mag);
        clamp(wide, res.value, ovf);
      end
      CMD_DIV: begin
        if (b == 0) begin
          res.flags[FLG_DZ] = 1'b1;
          res.value = (a < 0) ? MINV[WORD_BITS-1:0] : MAXV[WORD_BITS-1:0];
        end else begin
          mag = (ma << FRAC_BITS) / mb;
          rem = (ma << FRAC_BITS) % mb;
          if (rem >= mb - rem) mag = mag + 1;
          wide = neg ? -$signed(mag) : $signed(mag);
          clamp(wide, res.value, ovf);
        end
      end
      CMD_CMP: begin
        res.flags[FLG_LESS] = a < b;
        res.flags[FLG_EQUAL] = a == b;
        res.flags[FLG_GREATER] = a > b;
      end
      CMD_MAX: res.value = (a < b) ? b : a;
      CMD_MIN: res.value = (a > b) ? b : a;
      default: res = '0;
    endcase
    res.flags[FLG_OVF] = ovf;
    return res;
  endfunction

  assign pending = expected_q.size();

  always @(posedge clk) begin
    alu_result_t got, want;
    if (!rst_n) begin
      errors <= 0;
      results_seen <= 0;
      expected_q.delete();
    end else begin
      if (in_tvalid && in_tready) begin
        expected_q.push_back(predict_alu(in_tuser, in_tdata[WORD_BITS-1:0],
                                         in_tdata[2*WORD_BITS-1:WORD_BITS]));
      end
      if (out_tvalid && out_tready) begin
        results_seen <= results_seen + 1;
        got.value = out_tdata[WORD_BITS-1:0];
        got.flags = out_tuser;
        if (expected_q.size() == 0) begin
          $display("%0t: result word with nothing expected: value %h flags %b",
                   $time, got.value, got.flags);
          errors <= errors + 1;
        end else begin
          want = expected_q.pop_front();
          if (got.value !== want.value || got.flags !== want.flags) begin
            $display("%0t: mismatch: expected value %h flags %b, got value %h flags %b",
                     $time, want.value, want.flags, got.value, got.flags);
            errors <= errors + 1;
          end
        end
      end
    end
  end
endmodule

>>> tb/sv/tb.sv
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import falu_pkg::*;

  localparam int FRAC_BITS = FRAC_BITS_DEF;
  localparam int WORD_BITS = WORD_BITS_DEF;
  localparam int LATENCY = WORD_BITS + FRAC_BITS + 3;

  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic in_tvalid = 1'b0;
  logic in_tready;
  logic [((2*WORD_BITS+7)/8)*8-1:0] in_tdata = '0;
  logic [3:0] in_tuser = '0;
  logic out_tvalid;
  logic out_tready = 1'b0;
  logic [((WORD_BITS+7)/8)*8-1:0] out_tdata;
  logic [FLG_BITS-1:0] out_tuser;
  int errors, pending, results_seen;
  bit quiet_tail = 0;
  bit hold_off = 0;
  int words_sent = 0;

  always #2 clk = ~clk;

  fixed_point_alu #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) dut (.*);

  falu_checker #(.FRAC_BITS(FRAC_BITS), .WORD_BITS(WORD_BITS)) checker_i (.*);

  // Pick an operand with plenty of weight on edges and small values.
  function automatic logic [WORD_BITS-1:0] pick_operand();
    case ($urandom_range(0, 9))
      0: return {1'b0, {(WORD_BITS-1){1'b1}}};
      1: return {1'b1, {(WORD_BITS-1){1'b0}}};
      2: return WORD_BITS'($signed($urandom_range(0, 8)) - 4);
      3: return WORD_BITS'($signed($urandom_range(0, 2047)) - 1024);
      4: return WORD_BITS'($signed($urandom_range(0, 1 << 20)) - (1 << 19));
      default: return WORD_BITS'($urandom);
    endcase
  endfunction

  task automatic send_word(input logic [3:0] op, input logic [WORD_BITS-1:0] a,
                           input logic [WORD_BITS-1:0] b, input bit may_idle);
    if (may_idle && !quiet_tail && $urandom_range(0, 5) == 0) begin
      in_tvalid <= 1'b0;
      repeat ($urandom_range(1, 16)) @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tuser <= op;
    in_tdata <= $bits(in_tdata)'({b, a});
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    words_sent++;
    @(negedge clk);
  endtask

  // Receiver: random stalls, one long hold-off on request, none at the tail.
  initial begin
    @(posedge rst_n);
    forever begin
      @(negedge clk);
      if (hold_off) begin
        out_tready <= 1'b0;
        repeat (3 * LATENCY) @(negedge clk);
        hold_off = 0;
      end else if (!quiet_tail && $urandom_range(0, 7) == 0) begin
        out_tready <= 1'b0;
        repeat ($urandom_range(1, 16) - 1) @(negedge clk);
      end else begin
        out_tready <= 1'b1;
      end
    end
  end

  initial begin
    #2000000;
    $display("tb: done, errors");
    $finish;
  end

  initial begin
    logic [WORD_BITS-1:0] maxv, minv, r;
    int idle;
    maxv = {1'b0, {(WORD_BITS-1){1'b1}}};
    minv = {1'b1, {(WORD_BITS-1){1'b0}}};
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    // Directed corners.
    send_word(CMD_ADD, maxv, 1, 0);
    send_word(CMD_ADD, minv, minv, 0);
    send_word(CMD_SUB, minv, 1, 0);
    send_word(CMD_SUB, maxv, minv, 0);
    send_word(CMD_MUL, maxv, maxv, 0);
    send_word(CMD_MUL, minv, minv, 0);
    send_word(CMD_MUL, 32'h80, 32'hffffff80, 0);
    send_word(CMD_MUL, 32'h1, 32'h80, 0);
    send_word(CMD_MUL, 32'hffffffff, 32'h80, 0);
    send_word(CMD_DIV, 32'h100, 0, 0);
    send_word(CMD_DIV, 0, 0, 0);
    send_word(CMD_DIV, minv, 0, 0);
    send_word(CMD_DIV, minv, 32'hffffffff, 0);
    send_word(CMD_DIV, 32'h1, 32'h200, 0);
    send_word(CMD_DIV, 32'hffffffff, 32'h200, 0);
    send_word(CMD_CMP, 5, 5, 0);
    send_word(CMD_CMP, minv, maxv, 0);
    send_word(CMD_MAX, minv, maxv, 0);
    send_word(CMD_MIN, minv, maxv, 0);
    send_word(CMD_INC, maxv, 0, 0);
    send_word(CMD_DEC, minv, 0, 0);
    send_word(CMD_TO_INT, minv, 0, 0);
    send_word(CMD_FROM_INT, 32'h00800000, 0, 0);
    send_word(CMD_FROM_INT, 32'hff7fffff, 0, 0);
    send_word(4'd15, maxv, maxv, 0);
    for (int i = 0; i < 750; i++) begin
      if (i == 200) hold_off = 1;
      if (i == 400) begin
        // Sender pause until the pipeline has drained.
        in_tvalid <= 1'b0;
        while (pending != 0) @(negedge clk);
      end
      if (i == 680) quiet_tail = 1;
      r = pick_operand();
      send_word(4'($urandom_range(0, 15)), r, pick_operand(), 1);
    end
    in_tvalid <= 1'b0;
    idle = 0;
    while (pending != 0 && idle < 100 * LATENCY) begin
      @(negedge clk);
      idle++;
    end
    repeat (2 * LATENCY) @(negedge clk);
    $display("%0d operation words sent covering all opcodes and unused codes, %0d results",
             words_sent, results_seen);
    $display("checked, with random stalls, a long output hold-off and a full drain.");
    if (errors == 0 && pending == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end
endmodule
